// ===== sv/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdc_pkg
// shared types and constants for the pid controller with dead zone and clamp
// ----------------------------------------------------------------------------
package pdc_pkg;

    // apb address width: eight 32-bit registers at 4-byte spacing
    localparam int unsigned ADDR_W = 5;

    // register reset values
    localparam logic [15:0] PERIOD_RST   = 16'd100;
    localparam logic [15:0] OUT_LOW_RST  = 16'h8000;
    localparam logic [15:0] OUT_HIGH_RST = 16'h7FFF;

    // integrator and accumulator widths
    localparam int unsigned INTEG_W = 48;
    localparam int unsigned IPROD_W = 50;
    localparam int unsigned PROD_W  = 55;
    localparam int unsigned ACC_W   = 56;
    localparam int unsigned OPB_W   = 39;

    // division of the integrator magnitude by a constant, several bits per cycle
    localparam int unsigned DIV_CONST     = 1000;
    localparam int unsigned REM_W         = 10;
    localparam int unsigned DIV_BITS      = INTEG_W;
    localparam int unsigned DIV_STEP_BITS = 8;
    localparam int unsigned DIV_STEPS     = DIV_BITS / DIV_STEP_BITS;
    localparam int unsigned DIV_CNT_W     = $clog2(DIV_STEPS);
    // quotient magnitude stays below 2^47/1000 < 2^38
    localparam int unsigned QUOT_W        = 38;

    typedef enum logic [2:0] {
        REG_PERIOD    = 3'd0,
        REG_TARGET    = 3'd1,
        REG_GAIN_P    = 3'd2,
        REG_GAIN_I    = 3'd3,
        REG_GAIN_D    = 3'd4,
        REG_DEAD_BAND = 3'd5,
        REG_OUT_LOW   = 3'd6,
        REG_OUT_HIGH  = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        MS_PROP  = 2'd0,
        MS_INTEG = 2'd1,
        MS_DERIV = 2'd2
    } t_msel;

    typedef struct packed {
        logic [15:0] sample_period_ms;
        logic [15:0] target_value;
        logic [15:0] gain_prop;
        logic [15:0] gain_integ;
        logic [15:0] gain_deriv;
        logic [14:0] dead_band;
        logic [15:0] out_low;
        logic [15:0] out_high;
    } t_cfg;

    typedef struct packed {
        logic  load;
        logic  check;
        logic  integ;
        logic  div_init;
        logic  div_step;
        logic  mul_en;
        t_msel mul_sel;
        logic  acc_en;
        logic  acc_clr;
        logic  out_load;
        logic  commit;
    } t_cmd;

    typedef struct packed {
        logic due;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/pdc_regs.sv =====
// ----------------------------------------------------------------------------
// pdc_regs
// apb configuration register file
// ----------------------------------------------------------------------------
module pdc_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pdc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output pdc_pkg::t_cfg              o_cfg
);
    import pdc_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_PERIOD:    n_cfg.sample_period_ms = pwdata[15:0];
                REG_TARGET:    n_cfg.target_value     = pwdata[15:0];
                REG_GAIN_P:    n_cfg.gain_prop        = pwdata[15:0];
                REG_GAIN_I:    n_cfg.gain_integ       = pwdata[15:0];
                REG_GAIN_D:    n_cfg.gain_deriv       = pwdata[15:0];
                REG_DEAD_BAND: n_cfg.dead_band        = pwdata[14:0];
                REG_OUT_LOW:   n_cfg.out_low          = pwdata[15:0];
                REG_OUT_HIGH:  n_cfg.out_high         = pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_PERIOD:    prdata = {16'd0, r_cfg.sample_period_ms};
            REG_TARGET:    prdata = {16'd0, r_cfg.target_value};
            REG_GAIN_P:    prdata = {16'd0, r_cfg.gain_prop};
            REG_GAIN_I:    prdata = {16'd0, r_cfg.gain_integ};
            REG_GAIN_D:    prdata = {16'd0, r_cfg.gain_deriv};
            REG_DEAD_BAND: prdata = {17'd0, r_cfg.dead_band};
            REG_OUT_LOW:   prdata = {16'd0, r_cfg.out_low};
            REG_OUT_HIGH:  prdata = {16'd0, r_cfg.out_high};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_period_ms <= PERIOD_RST;
            r_cfg.target_value     <= '0;
            r_cfg.gain_prop        <= '0;
            r_cfg.gain_integ       <= '0;
            r_cfg.gain_deriv       <= '0;
            r_cfg.dead_band        <= '0;
            r_cfg.out_low          <= OUT_LOW_RST;
            r_cfg.out_high         <= OUT_HIGH_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== sv/pdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdc_ctrl
// sequencer that steps the datapath through one controller update, or a hold of the last drive
// ----------------------------------------------------------------------------
module pdc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pdc_pkg::t_sts i_sts,
    output pdc_pkg::t_cmd o_cmd
);
    import pdc_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_CHECK = 11'b000_0000_0010,
        S_INTEG = 11'b000_0000_0100,
        S_DIVLD = 11'b000_0000_1000,
        S_DIV   = 11'b000_0001_0000,
        S_MULP  = 11'b000_0010_0000,
        S_MULI  = 11'b000_0100_0000,
        S_MULD  = 11'b000_1000_0000,
        S_ACC   = 11'b001_0000_0000,
        S_DONE  = 11'b010_0000_0000,
        S_HOLD  = 11'b100_0000_0000
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [DIV_CNT_W-1:0] n_div_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        o_cmd     = '0;
        o_cmd.mul_sel = MS_PROP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.due ? S_INTEG : S_HOLD;
            end
            S_INTEG: begin
                o_cmd.integ = 1'b1;
                n_state     = S_DIVLD;
            end
            S_DIVLD: begin
                o_cmd.div_init = 1'b1;
                n_div_cnt      = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + 1'b1;
                if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_MULP;
                end
            end
            S_MULP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_PROP;
                n_state       = S_MULI;
            end
            S_MULI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_INTEG;
                o_cmd.acc_en  = 1'b1;
                o_cmd.acc_clr = 1'b1;
                n_state       = S_MULD;
            end
            S_MULD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_DERIV;
                o_cmd.acc_en  = 1'b1;
                n_state       = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_en = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.commit   = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_HOLD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

endmodule

// ===== sv/pdc_dp.sv =====
// ----------------------------------------------------------------------------
// pdc_dp
// datapath: error, integrator, divide by 1000, shared multiplier, clamp
// ----------------------------------------------------------------------------
module pdc_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pdc_pkg::t_cfg i_cfg,
    input  pdc_pkg::t_cmd i_cmd,
    output pdc_pkg::t_sts o_sts,
    input  logic [47:0]   i_in_data,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [15:0]   o_out_drive,
    output logic          o_out_updated
);
    import pdc_pkg::*;

    // item registers
    logic [15:0]               r_meas;
    logic [31:0]               r_now;
    logic [16:0]               r_err;
    logic [16:0]               r_dmeas;
    logic [31:0]               r_elapsed;
    logic signed [IPROD_W-1:0] r_iprod;

    // controller state
    logic [INTEG_W-1:0]        r_integ;
    logic [15:0]               r_last_meas;
    logic [31:0]               r_last_time;
    logic [15:0]               r_held;

    // divider
    logic [DIV_BITS-1:0]       r_dq;
    logic [REM_W-1:0]          r_rem;
    logic                      r_qneg;
    logic [DIV_BITS-1:0]       n_dq;
    logic [REM_W-1:0]          n_rem;

    // multiply and accumulate
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_psub;
    logic [ACC_W-1:0]          r_acc;

    // output register
    logic                      r_ov;
    logic                      r_oupd;
    logic [15:0]               r_odrive;

    logic [15:0]               w_in_meas;
    logic [31:0]               w_in_time;
    logic [16:0]               w_mag;
    logic                      w_integ_on;
    logic [INTEG_W+2:0]        w_sum;
    logic [INTEG_W-1:0]        w_sat;
    logic [15:0]               w_opa;
    logic [OPB_W-1:0]          w_opb;
    logic                      w_sub;
    logic [ACC_W-1:0]          w_base;
    logic [ACC_W-1:0]          w_pext;
    logic [INTEG_W-1:0]        w_res;
    logic [INTEG_W-1:0]        w_hi_ext;
    logic [INTEG_W-1:0]        w_lo_ext;
    logic [15:0]               w_clamped;

    assign w_in_meas = i_in_data[15:0];
    assign w_in_time = i_in_data[47:16];

    assign o_sts.due      = (r_elapsed >= {16'd0, i_cfg.sample_period_ms});
    assign o_sts.out_free = !r_ov || i_out_ready;

    assign o_out_valid   = r_ov;
    assign o_out_drive   = r_odrive;
    assign o_out_updated = r_oupd;

    // integrator update, saturating to 48 bits signed
    assign w_mag      = r_err[16] ? (17'd0 - r_err) : r_err;
    assign w_integ_on = (w_mag > {2'b00, i_cfg.dead_band});
    assign w_sum      = {{3{r_integ[INTEG_W-1]}}, r_integ} + {r_iprod[IPROD_W-1], r_iprod};

    always_comb begin
        if ((w_sum[INTEG_W+2:INTEG_W-1] == '0) || (w_sum[INTEG_W+2:INTEG_W-1] == '1)) begin
            w_sat = w_sum[INTEG_W-1:0];
        end else if (w_sum[INTEG_W+2]) begin
            w_sat = {1'b1, {(INTEG_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(INTEG_W-1){1'b1}}};
        end
    end

    // restoring division by the constant, several quotient bits per cycle
    always_comb begin
        logic [REM_W:0]      v_rem;
        logic [DIV_BITS-1:0] v_dq;
        v_rem = {1'b0, r_rem};
        v_dq  = r_dq;
        for (int k = 0; k < DIV_STEP_BITS; k++) begin
            v_rem = {v_rem[REM_W-1:0], v_dq[DIV_BITS-1]};
            v_dq  = {v_dq[DIV_BITS-2:0], 1'b0};
            if (v_rem >= (REM_W+1)'(DIV_CONST)) begin
                v_rem   = v_rem - (REM_W+1)'(DIV_CONST);
                v_dq[0] = 1'b1;
            end
        end
        n_rem = v_rem[REM_W-1:0];
        n_dq  = v_dq;
    end

    // shared multiplier operand selection
    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_PROP: begin
                w_opa = i_cfg.gain_prop;
                w_opb = {{(OPB_W-17){r_err[16]}}, r_err};
                w_sub = 1'b0;
            end
            MS_INTEG: begin
                w_opa = i_cfg.gain_integ;
                w_opb = {{(OPB_W-QUOT_W){1'b0}}, r_dq[QUOT_W-1:0]};
                w_sub = r_qneg;
            end
            MS_DERIV: begin
                w_opa = i_cfg.gain_deriv;
                w_opb = {{(OPB_W-17){r_dmeas[16]}}, r_dmeas};
                w_sub = 1'b1;
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
                w_sub = 1'b0;
            end
        endcase
    end

    assign w_base = i_cmd.acc_clr ? '0 : r_acc;
    assign w_pext = {r_prod[PROD_W-1], r_prod};

    // floor shift to q8.8, then clamp with the upper bound tested first
    assign w_res    = r_acc[ACC_W-1:8];
    assign w_hi_ext = {{(INTEG_W-16){i_cfg.out_high[15]}}, i_cfg.out_high};
    assign w_lo_ext = {{(INTEG_W-16){i_cfg.out_low[15]}}, i_cfg.out_low};

    always_comb begin
        if ($signed(w_res) > $signed(w_hi_ext)) begin
            w_clamped = i_cfg.out_high;
        end else if ($signed(w_res) < $signed(w_lo_ext)) begin
            w_clamped = i_cfg.out_low;
        end else begin
            w_clamped = w_res[15:0];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_meas    <= w_in_meas;
            r_now     <= w_in_time;
            r_elapsed <= w_in_time - r_last_time;
            r_err     <= {i_cfg.target_value[15], i_cfg.target_value}
                         - {w_in_meas[15], w_in_meas};
            r_dmeas   <= {w_in_meas[15], w_in_meas} - {r_last_meas[15], r_last_meas};
        end
        if (i_cmd.check) begin
            r_iprod <= $signed(r_err) * $signed({1'b0, r_elapsed});
        end
        if (i_cmd.div_init) begin
            r_dq   <= r_integ[INTEG_W-1] ? (INTEG_W'(0) - r_integ) : r_integ;
            r_rem  <= '0;
            r_qneg <= r_integ[INTEG_W-1];
        end else if (i_cmd.div_step) begin
            r_dq  <= n_dq;
            r_rem <= n_rem;
        end
        if (i_cmd.mul_en) begin
            r_prod <= $signed(w_opa) * $signed(w_opb);
            r_psub <= w_sub;
        end
        if (i_cmd.acc_en) begin
            r_acc <= r_psub ? (w_base - w_pext) : (w_base + w_pext);
        end
        if (i_cmd.out_load) begin
            r_oupd   <= i_cmd.commit;
            r_odrive <= i_cmd.commit ? w_clamped : r_held;
        end
    end

    // controller state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ     <= '0;
            r_last_meas <= '0;
            r_last_time <= '0;
            r_held      <= '0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cmd.integ && w_integ_on) begin
                r_integ <= w_sat;
            end
            if (i_cmd.commit) begin
                r_held      <= w_clamped;
                r_last_meas <= r_meas;
                r_last_time <= r_now;
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/pid_controller_deadzone_clamp_unit.sv =====
// ----------------------------------------------------------------------------
// pid_controller_deadzone_clamp_unit
// q8.8 pid controller with integrator dead zone, saturation and output clamp
// ----------------------------------------------------------------------------
// usage
//   slave stream: one beat per sample, measurement and millisecond time
//   master stream: one beat per input beat, drive plus an updated flag
//   apb port: eight 32-bit registers at byte offsets 0x00..0x1c, write only
//     while the block is idle; pready is tied high
// timing
//   when the sample period has elapsed the item runs through a sequencer:
//   error times elapsed, integrator update, divide by 1000 (eight quotient
//   bits per cycle), three products on one shared multiplier and the clamp;
//   the sequencer takes one beat at a time and is ready for the next beat
//   once the result is registered
//   an item that only holds the last drive passes the check and hold states
// reset
//   synchronous, active low: registers return to their reset values, the
//   integrator, last measurement, last update time and held drive clear
// stall
//   the result sits in an output register; the next beat is still taken,
//   and only the final step waits until the output register is free
// ----------------------------------------------------------------------------
module pid_controller_deadzone_clamp_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // slave stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [47:0]                s_axis_tdata,  // [15:0] measurement, [47:16] time_ms
    // master stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [15:0]                m_axis_tdata,  // [15:0] drive
    output logic                       m_axis_tuser,  // [0] updated
    // apb configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pdc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import pdc_pkg::*;

    t_cfg w_cfg;   // live register values
    t_cmd w_cmd;   // sequencer commands
    t_sts w_sts;   // datapath status

    pdc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // the sequencer owns the input handshake
    pdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // the datapath owns the output register
    pdc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_in_data     (s_axis_tdata),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_drive   (m_axis_tdata),
        .o_out_updated (m_axis_tuser)
    );

endmodule

// ===== sv/pdc_checker.sv =====
// ----------------------------------------------------------------------------
// pdc_checker
// port-level checks on the stream channels, bound to the top level
// ----------------------------------------------------------------------------
module pdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // a pending result stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped before it was taken");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // one item at a time: ready drops right after an input beat
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in progress");

    // a fresh result only follows a cycle in which the sequencer was busy
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a computation");

endmodule

bind pid_controller_deadzone_clamp_unit pdc_checker u_pdc_checker (.*);
